// File: sv/ntse_pkg.sv
// ntse_pkg: shared types, constants and byte helpers for the number-to-storage encoder.
// No dependencies; used by every module of the block.
package ntse_pkg;

   localparam int MAG_W        = 64;
   localparam int CNT_W        = 4;           // holds byte counts 1..9
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] SIGN_BIT  = 8'h80;
   localparam logic [7:0] COLL_BASE = 8'hC8;

   typedef enum logic {
      KIND_STORAGE   = 1'b0,
      KIND_COLLATION = 1'b1
   } kind_type;

   // classified request, as handed from front to back
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      kind_type         kind;
      logic             err;      // negative zero
      logic [CNT_W-1:0] nbytes;   // significant bytes, 1..8
      logic [CNT_W-1:0] count;    // bytes to emit, 1..9
   } desc_type;

   typedef struct packed {
      logic has_data;
      logic has_room;
   } q_status_type;

   function automatic logic [7:0] byte_of(input logic [MAG_W-1:0] mag, input logic [2:0] sel);
      byte_of = mag[{sel, 3'b000} +: 8];
   endfunction

   function automatic logic [CNT_W-1:0] sig_bytes(input logic [MAG_W-1:0] mag);
      logic [CNT_W-1:0] n;
      n = CNT_W'(1);
      for (int k = 1; k < 8; k++) begin
         if ((mag >> (8 * k)) != '0) begin
            n = CNT_W'(k + 1);
         end
      end
      sig_bytes = n;
   endfunction

endpackage

// File: sv/ntse_front.sv
// ntse_front: accepts requests and classifies them into descriptors (length, count, error).
// Depends on ntse_pkg.
module ntse_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ntse_pkg::desc_type    push_desc
);

   logic               valid_ff, valid_in;
   ntse_pkg::desc_type desc_ff, desc_in;
   logic               take;

   logic [ntse_pkg::CNT_W-1:0] n;
   logic [7:0]                 top_byte;
   logic                       extra;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_desc  = desc_ff;

   always_comb begin
      n        = ntse_pkg::sig_bytes(req_tdata);
      top_byte = ntse_pkg::byte_of(req_tdata, 3'(n - ntse_pkg::CNT_W'(1)));
      extra    = top_byte[7];

      desc_in.mag    = req_tdata;
      desc_in.neg    = req_tuser[0];
      desc_in.kind   = ntse_pkg::kind_type'(req_tuser[1]);
      desc_in.err    = req_tuser[0] && (req_tdata == '0);
      desc_in.nbytes = n;
      if (desc_in.err) begin
         desc_in.count = ntse_pkg::CNT_W'(1);
      end else if (desc_in.kind == ntse_pkg::KIND_COLLATION) begin
         desc_in.count = n + ntse_pkg::CNT_W'(1);
      end else begin
         desc_in.count = n + ntse_pkg::CNT_W'(extra);
      end

      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= desc_in;
      end
   end

endmodule

// File: sv/ntse_queue.sv
// ntse_queue: short register FIFO of descriptors between front and back.
// Depends on ntse_pkg.
module ntse_queue #(
   parameter int DEPTH = ntse_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  ntse_pkg::desc_type      push_desc,
   input  logic                    pop,
   output ntse_pkg::desc_type      head_desc,
   output ntse_pkg::q_status_type  status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   ntse_pkg::desc_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;
   logic          do_push, do_pop;

   assign status.has_data = (level_ff != '0);
   assign status.has_room = (level_ff != LW'(DEPTH));
   assign do_push   = push_valid && status.has_room;
   assign do_pop    = pop && status.has_data;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: sv/ntse_back.sv
// ntse_back: walks the head descriptor one byte per unstalled cycle into the registered response slot.
// Depends on ntse_pkg.
module ntse_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ntse_pkg::desc_type      head_desc,
   input  ntse_pkg::q_status_type  status,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast,
   output logic [0:0]              rsp_tuser
);

   logic [ntse_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff;
   logic       adv;
   logic [7:0] mag_byte;
   logic [2:0] sel;

   assign adv        = status.has_data && (!valid_ff || rsp_tready);
   assign last_in    = (idx_ff == head_desc.count - ntse_pkg::CNT_W'(1));
   assign pop        = adv && last_in;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

   always_comb begin
      // storage walks LSB first, collation MSB first after the prefix
      if (head_desc.kind == ntse_pkg::KIND_COLLATION) begin
         sel = 3'(head_desc.nbytes - idx_ff);
      end else begin
         sel = idx_ff[2:0];
      end
      mag_byte = ntse_pkg::byte_of(head_desc.mag, sel);

      byte_in = mag_byte;
      if (head_desc.err) begin
         byte_in = '0;
      end else if (head_desc.kind == ntse_pkg::KIND_COLLATION) begin
         if (idx_ff == '0) begin
            byte_in = head_desc.neg ? ntse_pkg::COLL_BASE - 8'(head_desc.nbytes)
                                    : ntse_pkg::COLL_BASE + 8'(head_desc.nbytes) - 8'd1;
         end else if (head_desc.neg) begin
            byte_in = ~mag_byte;
         end
      end else begin
         if (idx_ff == head_desc.nbytes) begin
            // sign byte after a top byte with its high bit set
            byte_in = head_desc.neg ? ntse_pkg::SIGN_BIT : 8'h00;
         end else if (head_desc.neg && last_in) begin
            byte_in = mag_byte | ntse_pkg::SIGN_BIT;
         end
      end

      if (adv) begin
         idx_in = last_in ? '0 : idx_ff + ntse_pkg::CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end

      if (adv) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         err_ff  <= head_desc.err;
      end
   end

endmodule

// File: sv/number_to_storage_encoder.sv
// number_to_storage_encoder: top level, order-preserving integer key encoder.
// Path: a request passes the front register, the queue and the output register before rsp_tvalid rises.
// Output: one response byte per cycle while rsp_tready is high; a request yields 1..9 bytes,
// paced by the single byte emitter in the back end. Next request is taken while bytes flow.
// Reset: synchronous, active high; clears front, queue and output valid state.
// Depends on ntse_pkg, ntse_front, ntse_queue, ntse_back.
module number_to_storage_encoder #(
   parameter int QUEUE_DEPTH = ntse_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] magnitude
   input  logic [1:0]  req_tuser,   // [0] negative, [1] kind (0 storage, 1 collation)
   // response channel, one encoded byte per transfer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // final byte of this number
   output logic [0:0]  rsp_tuser    // [0] error (negative zero)
);

   // front -> queue
   logic                   push_valid;
   ntse_pkg::desc_type     push_desc;
   // queue -> back
   ntse_pkg::desc_type     head_desc;
   ntse_pkg::q_status_type q_status;
   logic                   pop;

   // Front end: registers the request and works out byte length and emit count.
   ntse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (q_status.has_room),
      .push_desc  (push_desc)
   );

   // Decoupling queue: front keeps accepting while back is mid-number.
   ntse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_desc  (head_desc),
      .status     (q_status)
   );

   // Back end: emits bytes of the head descriptor, pops on its last byte.
   ntse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // error responses are single zero bytes
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("error response is not a lone zero byte");

   // a front entry blocked by a full queue is held unchanged
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      push_valid && !q_status.has_room |=> push_valid && $stable(push_desc))
      else $error("front entry lost while queue full");

   // back end only pops a queue that holds data
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.has_data)
      else $error("pop from empty queue");

   // no response is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule
